@@ hw/rtl/ordp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordp_pkg
// Shared types, register indexes and reset values for the one-wire reset and
// presence detector.
// ----------------------------------------------------------------------------
package ordp_pkg;

  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CountW  = 8;

  // Reset values in ticks of about 5 us
  localparam logic [CfgW-1:0] ResetLowDefault      = CfgW'(500 / 5);
  localparam logic [CfgW-1:0] RiseTimeoutDefault   = CfgW'(60 / 5);
  localparam logic [CfgW-1:0] PresStartDefault     = CfgW'(120 / 5);
  localparam logic [CfgW-1:0] PresEndDefault       = CfgW'(300 / 5);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RISE_TMO    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_PRES_START  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_PRES_END    = CfgIdxW'(3);

  typedef enum logic [2:0] {
    PH_OFF       = 3'd0,
    PH_ARMED     = 3'd1,
    PH_RESET_LOW = 3'd2,
    PH_RISING    = 3'd3,
    PH_WAIT_LOW  = 3'd4,
    PH_WAIT_HIGH = 3'd5,
    PH_FOUND     = 3'd6,
    PH_FAILED    = 3'd7
  } phase_e;

  typedef struct packed {
    logic cmd;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_level;
    logic [2:0] status;
    logic       short_detected;
  } out_item_t;

  typedef struct packed {
    logic [CfgW-1:0] reset_low_ticks;
    logic [CfgW-1:0] rise_timeout_ticks;
    logic [CfgW-1:0] presence_start_ticks;
    logic [CfgW-1:0] presence_end_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [CountW-1:0] tick_count;
    logic              drive;
    logic              short_flag;
  } seq_state_t;

endpackage

@@ hw/rtl/onewire_reset_presence_detect_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_reset_presence_detect_unit
// One-wire bus master reset pulse generator and presence detector.
// ----------------------------------------------------------------------------
// Each input item is either a start command or one timer tick (about 5 us)
// carrying the sampled bus level; every item yields exactly one result item
// with the transmit pin level, the sequence status and, on failure, whether
// the bus looked shorted. The block takes one item per clock while results drain:
// an input register feeds a single pass of next-state logic into a result
// register, so an item's result is offered once it has passed both registers
// and is held there until taken. While a finished result waits to be taken
// the input register still takes one more item, then the input stalls until
// the result drains. The four timing registers (reset low time, rise timeout,
// presence start and end timeouts, all in ticks) must be written by the user
// through the write port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module onewire_reset_presence_detect_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ordp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ordp_pkg::CfgW-1:0]     cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ordp_pkg::in_item_t            in_item_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ordp_pkg::out_item_t           out_item_o
);

  ordp_pkg::cfg_t       cfg;
  ordp_pkg::seq_state_t state_q, state_d;
  ordp_pkg::out_item_t  result_d, result_q;
  ordp_pkg::in_item_t   item_q;
  logic                 item_valid_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 advance;
  logic                 in_take;

  ordp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ordp_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Result register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  // Move the held item through the step logic into the result register
  assign advance    = item_valid_q && out_free;
  // Hold off the source only while the input register cannot drain
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Control: valid flags and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q       <= 1'b0;
      out_valid_q        <= 1'b0;
      state_q.phase      <= ordp_pkg::PH_OFF;
      state_q.tick_count <= '0;
      state_q.drive      <= 1'b1;
      state_q.short_flag <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = result_q;

  // The line is pulled low exactly during the reset pulse
  a_drive_low_in_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.drive == 1'b0) == (state_q.phase == ordp_pkg::PH_RESET_LOW))
    else $error("drive level out of step with reset phase");

  // Short flag is only reported on failure
  a_short_only_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.short_detected |->
      out_item_o.status == 3'(ordp_pkg::PH_FAILED))
    else $error("short reported outside failed status");

  // Every item that leaves the input register lands in the result register
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced item lost before result register");

  // The input register never holds an item while one is taken and none drains
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> !item_valid_q || advance)
    else $error("held item overwritten");

endmodule

@@ hw/rtl/ordp_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordp_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ordp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ordp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ordp_pkg::CfgW-1:0]     cfg_data_i,
  output ordp_pkg::cfg_t                cfg_o
);

  ordp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ordp_pkg::CFG_RESET_LOW:  cfg_d.reset_low_ticks      = cfg_data_i;
        ordp_pkg::CFG_RISE_TMO:   cfg_d.rise_timeout_ticks   = cfg_data_i;
        ordp_pkg::CFG_PRES_START: cfg_d.presence_start_ticks = cfg_data_i;
        ordp_pkg::CFG_PRES_END:   cfg_d.presence_end_ticks   = cfg_data_i;
        default:                  cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_ticks      <= ordp_pkg::ResetLowDefault;
      cfg_q.rise_timeout_ticks   <= ordp_pkg::RiseTimeoutDefault;
      cfg_q.presence_start_ticks <= ordp_pkg::PresStartDefault;
      cfg_q.presence_end_ticks   <= ordp_pkg::PresEndDefault;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/ordp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordp_step
// Next-state and result logic for one item: a start command or one tick.
// ----------------------------------------------------------------------------
module ordp_step (
  input  ordp_pkg::seq_state_t  state_i,
  input  ordp_pkg::in_item_t    item_i,
  input  ordp_pkg::cfg_t        cfg_i,
  output ordp_pkg::seq_state_t  state_o,
  output ordp_pkg::out_item_t   result_o
);

  logic [ordp_pkg::CountW-1:0] count_inc;

  // Saturating tick count
  assign count_inc = (state_i.tick_count == ordp_pkg::CountMax) ?
                     state_i.tick_count : state_i.tick_count + 1'b1;

  always_comb begin
    state_o            = state_i;
    state_o.tick_count = count_inc;
    if (item_i.cmd) begin
      state_o.phase      = ordp_pkg::PH_ARMED;
      state_o.tick_count = '0;
      state_o.short_flag = 1'b0;
      state_o.drive      = 1'b1;
    end else begin
      unique case (state_i.phase)
        ordp_pkg::PH_ARMED: begin
          state_o.drive      = 1'b0;
          state_o.phase      = ordp_pkg::PH_RESET_LOW;
          state_o.tick_count = '0;
        end
        ordp_pkg::PH_RESET_LOW: begin
          if (count_inc >= cfg_i.reset_low_ticks) begin
            state_o.drive      = 1'b1;
            state_o.phase      = ordp_pkg::PH_RISING;
            state_o.tick_count = '0;
          end
        end
        ordp_pkg::PH_RISING: begin
          if (item_i.line_level) begin
            state_o.phase      = ordp_pkg::PH_WAIT_LOW;
            state_o.tick_count = '0;
          end else if (count_inc >= cfg_i.rise_timeout_ticks) begin
            state_o.phase      = ordp_pkg::PH_FAILED;
            state_o.short_flag = 1'b1;
          end
        end
        ordp_pkg::PH_WAIT_LOW: begin
          if (!item_i.line_level) begin
            state_o.phase      = ordp_pkg::PH_WAIT_HIGH;
            state_o.tick_count = '0;
          end else if (count_inc >= cfg_i.presence_start_ticks) begin
            state_o.phase      = ordp_pkg::PH_FAILED;
            state_o.short_flag = 1'b0;
          end
        end
        ordp_pkg::PH_WAIT_HIGH: begin
          if (item_i.line_level) begin
            state_o.phase = ordp_pkg::PH_FOUND;
          end else if (count_inc >= cfg_i.presence_end_ticks) begin
            state_o.phase      = ordp_pkg::PH_FAILED;
            state_o.short_flag = 1'b0;
          end
        end
        default: begin
          // off, found and failed: only the count advances
        end
      endcase
    end
  end

  assign result_o.drive_level    = state_o.drive;
  assign result_o.status         = 3'(state_o.phase);
  assign result_o.short_detected = (state_o.phase == ordp_pkg::PH_FAILED) ?
                                   state_o.short_flag : 1'b0;

endmodule

@@ verif/onewire_reset_presence_detect_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_reset_presence_detect_unit_tb
// Self-checking testbench for the one-wire reset and presence detector.
// ----------------------------------------------------------------------------
// A short directed table walks every phase of the reset sequence, the short
// and no-device failures and the restart cases. Random phases then follow,
// each under its own set of timing registers (defaults, all zero, all ones
// and mixed or random values). Within a phase, most items form complete
// reset sequences: a simulated bus answers after delays picked around each
// timeout. A little noise and random restarts are mixed in. Every accepted
// item is run through a local predictor of the sequencer, and each result
// item is compared field by field with the oldest expected one. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module onewire_reset_presence_detect_unit_tb;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned IdlePct      = 12;
  localparam int unsigned RandomPhases = 5;
  localparam int unsigned PhaseItems   = 60;
  localparam int unsigned DirRows      = 26;
  // timing registers switch to the fast directed set at this row
  localparam int unsigned CfgSwitchRow = 4;

  // one directed item: cmd, line level, whether a result is typed in, result
  typedef struct packed {
    logic                cmd;
    logic                line_level;
    logic                typed;
    ordp_pkg::out_item_t res;
  } dir_row_t;

  localparam logic [5:0] Untyped = 6'b0;

  // Rows 0..3 run on the reset timing values; the rest run with a one-tick
  // reset pulse and all three timeouts at zero.
  localparam dir_row_t DirTable [DirRows] = '{
    {1'b0, 1'b1, 1'b1, 1'b1, ordp_pkg::PH_OFF,    1'b0},  // tick while off after reset
    {1'b1, 1'b0, 1'b1, 1'b1, ordp_pkg::PH_ARMED,  1'b0},  // start arms, line released
    {1'b0, 1'b0, Untyped},                                // pull low
    {1'b1, 1'b1, Untyped},                                // start while busy restarts
    {1'b0, 1'b0, Untyped},                                // reset low
    {1'b0, 1'b0, Untyped},                                // release, rising
    {1'b0, 1'b1, Untyped},                                // line rose, wait for device
    {1'b0, 1'b0, Untyped},                                // device pulls low
    {1'b0, 1'b1, Untyped},                                // device releases: found
    {1'b0, 1'b0, Untyped},                                // tick while found
    {1'b1, 1'b0, Untyped},                                // start after found
    {1'b0, 1'b0, Untyped},
    {1'b0, 1'b0, Untyped},
    {1'b0, 1'b0, 1'b1, 1'b1, ordp_pkg::PH_FAILED, 1'b1},  // line never rose: shorted
    {1'b0, 1'b1, 1'b1, 1'b1, ordp_pkg::PH_FAILED, 1'b1},  // tick while failed
    {1'b1, 1'b0, 1'b1, 1'b1, ordp_pkg::PH_ARMED,  1'b0},  // start clears the short flag
    {1'b0, 1'b1, Untyped},                                // level ignored while low
    {1'b0, 1'b1, Untyped},
    {1'b0, 1'b1, Untyped},
    {1'b0, 1'b1, 1'b1, 1'b1, ordp_pkg::PH_FAILED, 1'b0},  // no presence pulse begins
    {1'b1, 1'b1, Untyped},
    {1'b0, 1'b1, Untyped},
    {1'b0, 1'b0, Untyped},
    {1'b0, 1'b1, Untyped},
    {1'b0, 1'b0, Untyped},
    {1'b0, 1'b0, 1'b1, 1'b1, ordp_pkg::PH_FAILED, 1'b0}   // presence pulse never ends
  };

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [ordp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ordp_pkg::CfgW-1:0]    cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  ordp_pkg::in_item_t           in_item   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  ordp_pkg::out_item_t          out_item;

  // local copy of the sequencer and its timing registers
  ordp_pkg::cfg_t              timing;
  ordp_pkg::phase_e            seq_phase;
  logic [ordp_pkg::CountW-1:0] seq_ticks;
  logic                        seq_drive;
  logic                        seq_short;

  ordp_pkg::out_item_t status_due_q [$];
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;
  int unsigned in_idle_pct   = IdlePct;
  int unsigned out_stall_pct = IdlePct;

  onewire_reset_presence_detect_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the sequencer by one item and return the result it yields.
  function automatic ordp_pkg::out_item_t advance_reset_seq(ordp_pkg::in_item_t it);
    ordp_pkg::out_item_t r;
    if (it.cmd) begin
      seq_phase = ordp_pkg::PH_ARMED;
      seq_ticks = '0;
      seq_short = 1'b0;
      seq_drive = 1'b1;
    end else begin
      // the tick counter sticks at its top value
      if (seq_ticks != ordp_pkg::CountMax) seq_ticks = seq_ticks + 1'b1;
      case (seq_phase)
        ordp_pkg::PH_ARMED: begin
          seq_drive = 1'b0;
          seq_phase = ordp_pkg::PH_RESET_LOW;
          seq_ticks = '0;
        end
        ordp_pkg::PH_RESET_LOW: begin
          if (seq_ticks >= timing.reset_low_ticks) begin
            seq_drive = 1'b1;
            seq_phase = ordp_pkg::PH_RISING;
            seq_ticks = '0;
          end
        end
        ordp_pkg::PH_RISING: begin
          if (it.line_level) begin
            seq_phase = ordp_pkg::PH_WAIT_LOW;
            seq_ticks = '0;
          end else if (seq_ticks >= timing.rise_timeout_ticks) begin
            seq_phase = ordp_pkg::PH_FAILED;
            seq_short = 1'b1;
          end
        end
        ordp_pkg::PH_WAIT_LOW: begin
          if (!it.line_level) begin
            seq_phase = ordp_pkg::PH_WAIT_HIGH;
            seq_ticks = '0;
          end else if (seq_ticks >= timing.presence_start_ticks) begin
            seq_phase = ordp_pkg::PH_FAILED;
            seq_short = 1'b0;
          end
        end
        ordp_pkg::PH_WAIT_HIGH: begin
          if (it.line_level) begin
            seq_phase = ordp_pkg::PH_FOUND;
          end else if (seq_ticks >= timing.presence_end_ticks) begin
            seq_phase = ordp_pkg::PH_FAILED;
            seq_short = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    r.drive_level    = seq_drive;
    r.status         = seq_phase;
    r.short_detected = (seq_phase == ordp_pkg::PH_FAILED) && seq_short;
    return r;
  endfunction

  // Offer one item, idling at random first; on acceptance queue its result.
  task automatic send_item(ordp_pkg::in_item_t it, logic typed,
                           ordp_pkg::out_item_t typed_res);
    ordp_pkg::out_item_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_reset_seq(it);
    status_due_q.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  task automatic send_random_items(int unsigned n);
    ordp_pkg::in_item_t it;
    repeat (n) begin
      it.cmd        = 1'($urandom_range(1));
      it.line_level = 1'($urandom_range(1));
      send_item(it, 1'b0, '0);
    end
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four timing registers back to back, then one index beyond
  // the list, which the block must ignore.
  task automatic write_timing(ordp_pkg::cfg_t t);
    logic [ordp_pkg::CfgIdxW-1:0] spare_idx;
    spare_idx = ordp_pkg::CFG_PRES_END + ordp_pkg::CfgIdxW'($urandom_range(1, 4));
    cfg_we    <= 1'b1;
    cfg_index <= ordp_pkg::CFG_RESET_LOW;
    cfg_data  <= t.reset_low_ticks;
    @(posedge clk);
    cfg_index <= ordp_pkg::CFG_RISE_TMO;
    cfg_data  <= t.rise_timeout_ticks;
    @(posedge clk);
    cfg_index <= ordp_pkg::CFG_PRES_START;
    cfg_data  <= t.presence_start_ticks;
    @(posedge clk);
    cfg_index <= ordp_pkg::CFG_PRES_END;
    cfg_data  <= t.presence_end_ticks;
    @(posedge clk);
    cfg_index <= spare_idx;
    cfg_data  <= ordp_pkg::CfgW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    timing = t;
  endtask

  function automatic ordp_pkg::cfg_t phase_timing(int unsigned p);
    ordp_pkg::cfg_t t;
    int unsigned top;
    // even random phases keep to short times, odd ones use the full range
    top = p[0] ? 255 : 10;
    t.reset_low_ticks      = ordp_pkg::CfgW'($urandom_range(top));
    t.rise_timeout_ticks   = ordp_pkg::CfgW'($urandom_range(top));
    t.presence_start_ticks = ordp_pkg::CfgW'($urandom_range(top));
    t.presence_end_ticks   = ordp_pkg::CfgW'($urandom_range(top));
    case (p)
      0: t = {ordp_pkg::ResetLowDefault, ordp_pkg::RiseTimeoutDefault,
              ordp_pkg::PresStartDefault, ordp_pkg::PresEndDefault};
      1: t = '0;
      2: t = '1;
      3: t = {8'd0, 8'd255, 8'd0, 8'd255};
      default: begin
      end
    endcase
    return t;
  endfunction

  // Pick how long the bus takes to answer, often right at a timeout edge.
  function automatic int unsigned pick_delay(logic [ordp_pkg::CfgW-1:0] limit);
    int unsigned lim;
    lim = limit;
    case ($urandom_range(7))
      0:       return (lim == 0) ? 0 : lim - 1;
      1:       return lim;
      2:       return lim + 1;
      default: return $urandom_range((lim < 6) ? lim : 6);
    endcase
  endfunction

  // One reset sequence against a simulated bus; the bus level follows the
  // phase the sequencer is in, with a little noise and the odd restart.
  task automatic run_sequence();
    int unsigned        rise_d;
    int unsigned        pres_d;
    int unsigned        len_d;
    int unsigned        in_phase;
    ordp_pkg::phase_e   last;
    ordp_pkg::in_item_t it;
    rise_d = pick_delay(timing.rise_timeout_ticks);
    pres_d = pick_delay(timing.presence_start_ticks);
    len_d  = pick_delay(timing.presence_end_ticks);
    it.cmd        = 1'b1;
    it.line_level = 1'($urandom_range(1));
    send_item(it, 1'b0, '0);
    last     = seq_phase;
    in_phase = 0;
    while (seq_phase != ordp_pkg::PH_FOUND && seq_phase != ordp_pkg::PH_FAILED) begin
      if (seq_phase != last) begin
        last     = seq_phase;
        in_phase = 0;
      end
      it.cmd = 1'b0;
      case (seq_phase)
        ordp_pkg::PH_RISING:    it.line_level = (in_phase >= rise_d);
        ordp_pkg::PH_WAIT_LOW:  it.line_level = (in_phase < pres_d);
        ordp_pkg::PH_WAIT_HIGH: it.line_level = (in_phase >= len_d);
        default:                it.line_level = 1'($urandom_range(1));
      endcase
      // glitch the line now and then, and rarely restart mid-sequence
      if ($urandom_range(99) < 4) it.line_level = ~it.line_level;
      if ($urandom_range(199) == 0) it.cmd = 1'b1;
      send_item(it, 1'b0, '0);
      in_phase++;
    end
    // a few items after the end: ticks in found or failed, or a restart
    send_random_items($urandom_range(3));
  endtask

  // Result side: check each accepted result, then pick the next stall.
  always @(posedge clk) begin
    ordp_pkg::out_item_t want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (status_due_q.size() == 0) begin
        $error("result item with none expected: %p", out_item);
        fail_count++;
      end else begin
        want = status_due_q.pop_front();
        if (out_item.drive_level !== want.drive_level) begin
          $error("drive_level: expected %0b, got %0b", want.drive_level,
                 out_item.drive_level);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.short_detected !== want.short_detected) begin
          $error("short_detected: expected %0b, got %0b", want.short_detected,
                 out_item.short_detected);
          fail_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned        i;
    int unsigned        p;
    int unsigned        phase_start;
    ordp_pkg::in_item_t it;
    timing    = {ordp_pkg::ResetLowDefault, ordp_pkg::RiseTimeoutDefault,
                 ordp_pkg::PresStartDefault, ordp_pkg::PresEndDefault};
    seq_phase = ordp_pkg::PH_OFF;
    seq_ticks = '0;
    seq_drive = 1'b1;
    seq_short = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset values first, then a one-tick reset pulse with
    // zero timeouts so that each outcome takes only a handful of items.
    for (i = 0; i < DirRows; i++) begin
      if (i == CfgSwitchRow) begin
        wait_drained();
        write_timing({8'd1, 8'd0, 8'd0, 8'd0});
      end
      it.cmd        = DirTable[i].cmd;
      it.line_level = DirTable[i].line_level;
      send_item(it, DirTable[i].typed, DirTable[i].res);
    end
    wait_drained();

    // Random phases, each under fresh timing values written while idle.
    for (p = 0; p < RandomPhases; p++) begin
      write_timing(phase_timing(p));
      // the all-ones phase runs with no idling on either side
      in_idle_pct   = (p == 2) ? 0 : IdlePct;
      out_stall_pct = (p == 2) ? 0 : IdlePct;
      phase_start   = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(9) == 0) send_random_items($urandom_range(1, 5));
        run_sequence();
        // now and then hold the sender until every result is back
        if ($urandom_range(7) == 0) wait_drained();
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
